FILE: sv/timestamped_audio_ring_buffer_core_assert.svh
// assertion macros shared by the ring buffer core
`ifndef TIMESTAMPED_AUDIO_RING_BUFFER_CORE_ASSERT_SVH
`define TIMESTAMPED_AUDIO_RING_BUFFER_CORE_ASSERT_SVH

// same-cycle implication, checked on every clk edge outside reset
`define TARB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TARB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tarb_pkg.sv
`timescale 1ns / 1ps

package tarb_pkg;

    // frame store depth, a power of two so the slot is the low position bits
    localparam int CAPACITY_FRAMES = 65536;
    localparam int SLOT_BITS       = $clog2(CAPACITY_FRAMES);
    localparam int POSITION_BITS   = 48;
    localparam int POS_IN_BITS     = 48;
    localparam int SAMPLE_BITS     = 16;
    localparam int FRAME_BITS      = 2 * SAMPLE_BITS;
    localparam int LOOKAHEAD_BITS  = 17;
    localparam int CHAN_BITS       = 2;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = LOOKAHEAD_BITS;

    localparam logic [POSITION_BITS-1:0]  CAP_POS         = POSITION_BITS'(CAPACITY_FRAMES);
    localparam logic [CHAN_BITS-1:0]      CHAN_RESET      = CHAN_BITS'(2);
    localparam logic [LOOKAHEAD_BITS-1:0] LOOKAHEAD_RESET = LOOKAHEAD_BITS'(48000);

    typedef enum logic [1:0] {
        REQ_WRITE    = 2'd0,
        REQ_SNAPSHOT = 2'd1,
        REQ_CONSUME  = 2'd2,
        REQ_SEEK     = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CHANNELS  = 2'd0,
        CFG_LOOKAHEAD = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
        logic update;
        logic lead;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } ctrl_stat_t;

endpackage

FILE: sv/tarb_ctrl.sv
`timescale 1ns / 1ps

module tarb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tarb_pkg::ctrl_stat_t stat,
    output tarb_pkg::ctrl_cmd_t  cmd,
    output logic                 busy
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_UPDATE = 6'b001000,
        ST_LEAD   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_LEAD;
            ST_LEAD:   state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.clear   = (state_reg == ST_CLEAR);
    assign cmd.capture = (state_reg == ST_IDLE) && start;
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.update  = (state_reg == ST_UPDATE);
    assign cmd.lead    = (state_reg == ST_LEAD);
    assign cmd.finish  = (state_reg == ST_DONE);
    assign busy        = (state_reg != ST_IDLE);

endmodule

FILE: sv/tarb_datapath.sv
`timescale 1ns / 1ps

module tarb_datapath
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  tarb_pkg::ctrl_cmd_t                      cmd,
    output tarb_pkg::ctrl_stat_t                     stat,
    input  logic                                     cfg_valid,
    input  logic [tarb_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [tarb_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic [1:0]                               req_type,
    input  logic signed [tarb_pkg::POS_IN_BITS-1:0]  position,
    input  logic signed [tarb_pkg::SAMPLE_BITS-1:0]  sample_ch0,
    input  logic signed [tarb_pkg::SAMPLE_BITS-1:0]  sample_ch1,
    input  logic                                     last_in_run,
    output logic signed [tarb_pkg::SAMPLE_BITS-1:0]  read_ch0,
    output logic signed [tarb_pkg::SAMPLE_BITS-1:0]  read_ch1,
    output logic                                     in_window,
    output logic                                     underrun,
    output logic                                     fill_needed,
    output logic                                     last_out,
    output logic                                     done
);

    localparam int P  = tarb_pkg::POSITION_BITS;
    localparam int SB = tarb_pkg::SAMPLE_BITS;

    // frame store
    logic [tarb_pkg::FRAME_BITS-1:0] mem [tarb_pkg::CAPACITY_FRAMES];
    logic [tarb_pkg::FRAME_BITS-1:0] rdata_reg;
    logic [tarb_pkg::SLOT_BITS-1:0]  mem_addr;
    logic [tarb_pkg::FRAME_BITS-1:0] mem_wdata;
    logic                            mem_we;
    logic                            mem_re;

    logic [tarb_pkg::SLOT_BITS-1:0]  clr_cnt_reg;

    // config
    logic [tarb_pkg::CHAN_BITS-1:0]      chan_reg;
    logic [tarb_pkg::LOOKAHEAD_BITS-1:0] look_reg;

    // item
    tarb_pkg::req_t       req_reg;
    logic signed [P-1:0]  pos_reg;
    logic signed [SB-1:0] s0_reg;
    logic signed [SB-1:0] s1_reg;
    logic                 last_reg;

    logic signed [P-1:0]  head_reg;
    logic signed [P-1:0]  cursor_reg;

    logic signed [P-1:0]  s_sel;
    logic                 ge0_reg;
    logic                 lt_head_reg;
    logic [P-1:0]         dist_reg;
    logic                 under_reg;
    logic signed [P-1:0]  nxt_reg;
    logic                 win_reg;
    logic [P:0]           diff;
    logic [P-1:0]         lead_reg;

    logic signed [SB-1:0] rd0_reg;
    logic signed [SB-1:0] rd1_reg;
    logic                 inwin_reg;
    logic                 under_out_reg;
    logic                 fill_reg;
    logic                 last_out_reg;
    logic                 done_reg;

    // config writes, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= tarb_pkg::CHAN_RESET;
            look_reg <= tarb_pkg::LOOKAHEAD_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tarb_pkg::CFG_CHANNELS)
            begin
                chan_reg <= cfg_data[tarb_pkg::CHAN_BITS-1:0];
            end
            else if (cfg_index == tarb_pkg::CFG_LOOKAHEAD)
            begin
                look_reg <= cfg_data;
            end
        end
    end

    // clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + tarb_pkg::SLOT_BITS'(1);
        end
    end

    assign stat.clear_last = cmd.clear && (clr_cnt_reg == {tarb_pkg::SLOT_BITS{1'b1}});

    // read address: cursor for consume, request position otherwise
    assign s_sel = (req_reg == tarb_pkg::REQ_CONSUME) ? cursor_reg : pos_reg;

    assign mem_addr  = cmd.clear ? clr_cnt_reg : s_sel[tarb_pkg::SLOT_BITS-1:0];
    assign mem_we    = cmd.clear || (cmd.exec && (req_reg == tarb_pkg::REQ_WRITE));
    assign mem_wdata = cmd.clear ? '0 : {s1_reg, s0_reg};
    assign mem_re    = cmd.exec;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // item capture and per-step payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= tarb_pkg::req_t'(req_type);
            pos_reg  <= P'(position);
            s0_reg   <= sample_ch0;
            s1_reg   <= sample_ch1;
            last_reg <= last_in_run;
        end
        if (cmd.exec)
        begin
            ge0_reg     <= !s_sel[P-1];
            lt_head_reg <= (s_sel < head_reg);
            dist_reg    <= P'(head_reg - s_sel);
            under_reg   <= (req_reg == tarb_pkg::REQ_CONSUME) && (cursor_reg >= head_reg);
            nxt_reg     <= pos_reg + P'(1);
        end
        if (cmd.update)
        begin
            win_reg <= ((req_reg == tarb_pkg::REQ_SNAPSHOT) ||
                        (req_reg == tarb_pkg::REQ_CONSUME)) &&
                       ge0_reg && lt_head_reg && (dist_reg <= tarb_pkg::CAP_POS);
        end
        if (cmd.lead)
        begin
            // head below cursor counts as no lead
            lead_reg <= diff[P] ? '0 : diff[P-1:0];
        end
        if (cmd.finish)
        begin
            rd0_reg       <= win_reg ? rdata_reg[SB-1:0] : '0;
            rd1_reg       <= (win_reg && chan_reg[1]) ? rdata_reg[2*SB-1:SB] : '0;
            inwin_reg     <= win_reg;
            under_out_reg <= under_reg;
            fill_reg      <= (lead_reg < P'(look_reg));
            last_out_reg  <= last_reg;
        end
    end

    assign diff = {head_reg[P-1], head_reg} - {cursor_reg[P-1], cursor_reg};

    // head and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            cursor_reg <= '0;
        end
        else if (cmd.update)
        begin
            case (req_reg)
                tarb_pkg::REQ_WRITE:
                begin
                    if (nxt_reg > head_reg)
                    begin
                        head_reg <= nxt_reg;
                    end
                end
                tarb_pkg::REQ_CONSUME:
                begin
                    cursor_reg <= cursor_reg + P'(1);
                end
                tarb_pkg::REQ_SEEK:
                begin
                    head_reg   <= pos_reg;
                    cursor_reg <= pos_reg;
                end
                default:
                begin
                    head_reg <= head_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign read_ch0    = rd0_reg;
    assign read_ch1    = rd1_reg;
    assign in_window   = inwin_reg;
    assign underrun    = under_out_reg;
    assign fill_needed = fill_reg;
    assign last_out    = last_out_reg;
    assign done        = done_reg;

endmodule

FILE: sv/timestamped_audio_ring_buffer_core.sv
`timescale 1ns / 1ps
`include "timestamped_audio_ring_buffer_core_assert.svh"

// audio frame store addressed by absolute signed sample position. a request is
// taken at a clk edge with start high and busy low; each request gives exactly
// one result word, shown for one cycle with done high, and the receiver cannot
// stall it, so it must take every done cycle. an item occupies the block from
// accept to the next possible accept while the controller steps through
// address/compare, state update, lead subtract and result load, and the result
// strobe comes in the cycle after the last step. after reset the frame store is
// swept to zero one entry a cycle with busy high; configuration writes are
// taken throughout, cfg_ready is always high.
module timestamped_audio_ring_buffer_core
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    // request word
    input  logic                                     start,
    output logic                                     busy,
    input  logic [1:0]                               req_type,
    input  logic signed [tarb_pkg::POS_IN_BITS-1:0]  position,
    input  logic signed [tarb_pkg::SAMPLE_BITS-1:0]  sample_ch0,
    input  logic signed [tarb_pkg::SAMPLE_BITS-1:0]  sample_ch1,
    input  logic                                     last_in_run,
    // result word
    output logic                                     done,
    output logic signed [tarb_pkg::SAMPLE_BITS-1:0]  read_ch0,
    output logic signed [tarb_pkg::SAMPLE_BITS-1:0]  read_ch1,
    output logic                                     in_window,
    output logic                                     underrun,
    output logic                                     fill_needed,
    output logic                                     last_out,
    // configuration write
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [tarb_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [tarb_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    tarb_pkg::ctrl_cmd_t  cmd;
    tarb_pkg::ctrl_stat_t stat;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: clear sweep, then one request at a time
    tarb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // frame store, head and cursor, window and lead checks, result registers
    tarb_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .position    (position),
        .sample_ch0  (sample_ch0),
        .sample_ch1  (sample_ch1),
        .last_in_run (last_in_run),
        .read_ch0    (read_ch0),
        .read_ch1    (read_ch1),
        .in_window   (in_window),
        .underrun    (underrun),
        .fill_needed (fill_needed),
        .last_out    (last_out),
        .done        (done)
    );

    // an accepted request keeps the block busy in the next cycle
    `TARB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
    // the result strobe only comes once the sequencer is back at rest
    `TARB_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
    // out-of-window reads carry zero samples
    `TARB_ASSERT_NOW(a_zero_outside, done && !in_window, (read_ch0 == '0) && (read_ch1 == '0),
        "nonzero sample outside window")
    // a cursor at or past the head can never be in window
    `TARB_ASSERT_NOW(a_underrun_window, done && underrun, !in_window,
        "underrun with in-window data")

endmodule

FILE: verif/timestamped_audio_ring_buffer_core_tb.sv
`timescale 1ns / 1ps

// ring buffer core bench: directed corner cases at reset settings, then phases of
// random audio runs (seek, write burst, consume / snapshot reads) mixed with random
// noise requests, each phase under a new channel count and lookahead setting.
// a scoreboard object keeps its own copy of the frame store, head and cursor and
// checks every done word against the oldest predicted word
module timestamped_audio_ring_buffer_core_tb;
    import tarb_pkg::*;

    localparam int     POS_W         = POSITION_BITS;
    localparam int     RANDOM_ITEMS  = 1100;
    localparam int     PHASES        = 6;
    localparam int     LONG_GAP_MAX  = 40;
    localparam int     DRAIN_CYCLES  = 12;   // longer than an item takes from accept to its result
    localparam int     PRINT_LIMIT   = 40;
    // clearing sweep after reset plus every item at its longest gap, taken several times
    localparam longint CYCLE_LIMIT   = 800000;

    // register indexes that the block must ignore
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HI = 2'd3;

    typedef logic signed [POS_W-1:0]       pos_t;
    typedef logic signed [SAMPLE_BITS-1:0] smp_t;

    localparam pos_t MAX_POS = {1'b0, {(POS_W-1){1'b1}}};
    localparam pos_t MIN_POS = {1'b1, {(POS_W-1){1'b0}}};

    // one result word as the block shows it
    typedef struct packed {
        smp_t ch0;
        smp_t ch1;
        logic win;
        logic under;
        logic fill;
        logic last;
    } readout_t;

    // predicts each result word from its own copy of the block state
    class ring_scoreboard;
        logic [FRAME_BITS-1:0]     frames [CAPACITY_FRAMES];
        pos_t                      head;
        pos_t                      cursor;
        logic [CHAN_BITS-1:0]      chans;
        logic [LOOKAHEAD_BITS-1:0] lookahead;
        readout_t                  due_readouts [$];
        int                        errors;
        int                        checked;
        int                        hits;
        int                        underruns;
        int                        mono_hits;
        int                        req_count [4];

        function new();
            foreach (frames[i]) frames[i] = '0;
            head      = '0;
            cursor    = '0;
            chans     = CHAN_RESET;
            lookahead = LOOKAHEAD_RESET;
            errors    = 0;
            checked   = 0;
            hits      = 0;
            underruns = 0;
            mono_hits = 0;
            foreach (req_count[i]) req_count[i] = 0;
        endfunction

        function int outstanding();
            return due_readouts.size();
        endfunction

        function void set_config(logic [CFG_IDX_BITS-1:0] idx,
                                 logic [CFG_DATA_BITS-1:0] data);
            if (idx == CFG_CHANNELS)
                chans = data[CHAN_BITS-1:0];
            else if (idx == CFG_LOOKAHEAD)
                lookahead = data;
        endfunction

        // stored data is valid from head - capacity up to head - 1, never below zero
        function void read_into(pos_t s, inout readout_t r);
            logic [POS_W-1:0]      lag;
            logic [FRAME_BITS-1:0] f;
            if (s < 0 || s >= head)
                return;
            lag = head - s;
            if (lag > CAP_POS)
                return;
            f     = frames[s[SLOT_BITS-1:0]];
            r.ch0 = f[SAMPLE_BITS-1:0];
            r.ch1 = (chans <= 1) ? '0 : f[FRAME_BITS-1:SAMPLE_BITS];
            r.win = 1'b1;
        endfunction

        function void note_request(req_t req, pos_t pos, smp_t s0, smp_t s1, logic last);
            readout_t         r;
            pos_t             nxt;
            pos_t             top;
            logic [POS_W-1:0] lead;
            r = '0;
            req_count[int'(req)]++;
            case (req)
                REQ_WRITE:
                begin
                    // slot is the low bits, which is the non-negative residue
                    frames[pos[SLOT_BITS-1:0]] = {s1, s0};
                    nxt = pos + 1;
                    // a wrap to the most negative position never raises the head
                    if (nxt > head)
                        head = nxt;
                end
                REQ_SNAPSHOT:
                    read_into(pos, r);
                REQ_CONSUME:
                begin
                    r.under = (cursor >= head);
                    read_into(cursor, r);
                    cursor = cursor + 1;
                end
                default:
                begin
                    head   = pos;
                    cursor = pos;
                end
            endcase
            // fill status after the update, head lifted to the cursor if it lags
            top    = (head < cursor) ? cursor : head;
            lead   = top - cursor;
            r.fill = (lead < lookahead);
            r.last = last;
            if (r.win)
                hits++;
            if (r.win && chans <= 1)
                mono_hits++;
            if (r.under)
                underruns++;
            due_readouts.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("mismatch at %0t, word %0d, %s: got %0d expected %0d",
                         $realtime, checked, what, got, want);
        endtask

        task check_result(readout_t got);
            readout_t want;
            if (due_readouts.size() == 0)
            begin
                report("done with no word pending", 1, 0);
                return;
            end
            want = due_readouts.pop_front();
            checked++;
            if (got.ch0 !== want.ch0)
                report("read_ch0", got.ch0, want.ch0);
            if (got.ch1 !== want.ch1)
                report("read_ch1", got.ch1, want.ch1);
            if (got.win !== want.win)
                report("in_window", got.win, want.win);
            if (got.under !== want.under)
                report("underrun", got.under, want.under);
            if (got.fill !== want.fill)
                report("fill_needed", got.fill, want.fill);
            if (got.last !== want.last)
                report("last_out", got.last, want.last);
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                req_type;
    pos_t                      position;
    smp_t                      sample_ch0;
    smp_t                      sample_ch1;
    logic                      last_in_run;
    logic                      done;
    smp_t                      read_ch0;
    smp_t                      read_ch1;
    logic                      in_window;
    logic                      underrun;
    logic                      fill_needed;
    logic                      last_out;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    ring_scoreboard sb;
    longint         cycles = 0;
    int             items_sent = 0;
    bit             no_idle = 1'b0;   // set for gap-free stretches

    // settings per random phase, extremes of both registers among them
    int unsigned chan_plan [PHASES] = '{1, 3, 0, 2, 1, 2};
    int unsigned look_plan [PHASES] = '{0, 131071, 65536, 1, 16, 48000};

    timestamped_audio_ring_buffer_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .position    (position),
        .sample_ch0  (sample_ch0),
        .sample_ch1  (sample_ch1),
        .last_in_run (last_in_run),
        .done        (done),
        .read_ch0    (read_ch0),
        .read_ch1    (read_ch1),
        .in_window   (in_window),
        .underrun    (underrun),
        .fill_needed (fill_needed),
        .last_out    (last_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    // watchdog on the cycle count
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout: still waiting after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    // sample at the edge: all bench inputs move by nonblocking assignment, so the
    // values read here are the ones the block sees at this same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // the result strobe can't be held off, so every done cycle is a word
            if (done)
                sb.check_result({read_ch0, read_ch1, in_window, underrun, fill_needed,
                                 last_out});
            if (start && !busy)
                sb.note_request(req_t'(req_type), position, sample_ch0, sample_ch1,
                                last_in_run);
            if (cfg_valid && cfg_ready)
                sb.set_config(cfg_index, cfg_data);
        end
    end

    function automatic pos_t any_position();
        return pos_t'({$urandom(), $urandom()});
    endfunction

    function automatic smp_t any_sample();
        return smp_t'($urandom());
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, LONG_GAP_MAX);
    endfunction

    // start stays high across back-to-back words, dropped only over a gap or in a drain
    task automatic send_item(req_t req, pos_t pos, smp_t s0, smp_t s1, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= req;
        position    <= pos;
        sample_ch0  <= s0;
        sample_ch1  <= s1;
        last_in_run <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    // valid drops for one cycle after each write
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // let every pending word come back, then let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // where a run starts: near zero, near capacity multiples, anywhere positive,
    // just below the largest position (so the head increment wraps), negative, near the most
    // negative position
    function automatic pos_t pick_base();
        pos_t p;
        case ($urandom_range(0, 5))
            0: return pos_t'($urandom_range(0, 2000));
            1: return pos_t'(CAPACITY_FRAMES * $urandom_range(1, 8))
                      - pos_t'($urandom_range(0, 20));
            2:
            begin
                p = any_position();
                p[POS_W-1] = 1'b0;
                return p;
            end
            3: return MAX_POS - pos_t'($urandom_range(0, 30));
            4: return -pos_t'($urandom_range(1, 300));
            default: return MIN_POS + pos_t'($urandom_range(0, 30));
        endcase
    endfunction

    // a well-formed producer/consumer run with random content
    task automatic audio_run();
        pos_t base;
        int   n_wr;
        int   n_rd;
        int   k;
        base    = pick_base();
        no_idle = ($urandom_range(0, 3) == 0);
        n_wr    = $urandom_range(1, 24);
        // reading past what was written drives the cursor into underrun
        n_rd    = $urandom_range(0, n_wr + 4);
        if ($urandom_range(0, 3) != 0)
            send_item(REQ_SEEK, base, any_sample(), any_sample(), $urandom_range(0, 1));
        for (k = 0; k < n_wr; k++)
            send_item(REQ_WRITE, base + pos_t'(k), any_sample(), any_sample(), k == n_wr - 1);
        // a frame about one capacity ahead can push the oldest frames out of the window
        if ($urandom_range(0, 4) == 0)
            send_item(REQ_WRITE, base + pos_t'(CAPACITY_FRAMES) + pos_t'($urandom_range(0, 3)) - 1,
                      any_sample(), any_sample(), 1'b1);
        for (k = 0; k < n_rd; k++)
        begin
            if ($urandom_range(0, 2) == 0)
                send_item(REQ_SNAPSHOT, base + pos_t'($urandom_range(0, n_wr + 5)) - 3,
                          any_sample(), any_sample(), k == n_rd - 1);
            else
                // position is don't-care for a consume, so let it toggle freely
                send_item(REQ_CONSUME, any_position(), any_sample(), any_sample(),
                          k == n_rd - 1);
        end
        no_idle = 1'b0;
    endtask

    // fully random requests anywhere in the position range
    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
            send_item(req_t'($urandom_range(0, 3)), any_position(), any_sample(), any_sample(),
                      $urandom_range(0, 1));
    endtask

    task automatic random_phase(int quota);
        int stop_at;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 75)
                audio_run();
            else
                noise_burst();
        end
    endtask

    // corner cases under the reset settings (stereo, lookahead 48000)
    task automatic directed_items();
        // empty store, then a consume with the cursor already at the head
        send_item(REQ_SNAPSHOT, 0, 0, 0, 1'b0);
        send_item(REQ_CONSUME, 0, 0, 0, 1'b1);
        send_item(REQ_SEEK, 0, 0, 0, 1'b0);
        // sample extremes in both channels
        send_item(REQ_WRITE, 0, 16'sh7fff, -16'sh8000, 1'b0);
        send_item(REQ_WRITE, 1, -16'sh0001, 16'sh0000, 1'b1);
        send_item(REQ_SNAPSHOT, 0, 0, 0, 1'b0);
        send_item(REQ_SNAPSHOT, 1, 0, 0, 1'b0);
        // negative position and a position at the head are both out of window
        send_item(REQ_SNAPSHOT, -1, 0, 0, 1'b0);
        send_item(REQ_SNAPSHOT, 2, 0, 0, 1'b1);
        // two good consumes then underrun
        send_item(REQ_CONSUME, 0, 0, 0, 1'b0);
        send_item(REQ_CONSUME, 0, 0, 0, 1'b0);
        send_item(REQ_CONSUME, 0, 0, 0, 1'b1);
        // head jumps to capacity + 2: position 2 is exactly capacity behind, 1 is past it
        send_item(REQ_WRITE, pos_t'(CAPACITY_FRAMES + 1), 16'sh1234, -16'sh1234, 1'b0);
        send_item(REQ_SNAPSHOT, 2, 0, 0, 1'b0);
        send_item(REQ_SNAPSHOT, 1, 0, 0, 1'b1);
        // negative writes land in the top and bottom slots, head untouched
        send_item(REQ_WRITE, -1, 16'sh0a5a, 16'sh05a5, 1'b0);
        send_item(REQ_WRITE, MIN_POS, -16'sh5a5b, 16'sh7a5a, 1'b1);
        // write at the largest position: the head increment wraps and is dropped
        send_item(REQ_SEEK, MAX_POS, 0, 0, 1'b0);
        send_item(REQ_WRITE, MAX_POS, 16'sh4321, 16'sh1357, 1'b0);
        // consume at the top: underrun, cursor wraps to the most negative position
        send_item(REQ_CONSUME, 0, 0, 0, 1'b1);
        // fill status right at the lookahead boundary
        send_item(REQ_SEEK, 1000, 0, 0, 1'b0);
        send_item(REQ_WRITE, pos_t'(1000 + 47998), 16'sh0001, 16'sh0002, 1'b0);
        send_item(REQ_WRITE, pos_t'(1000 + 47999), 16'sh0003, 16'sh0004, 1'b1);
        // alternating bit patterns on the position bus
        send_item(REQ_SNAPSHOT, pos_t'(48'haaaa_aaaa_aaaa), 16'sh5555, -16'sh5556, 1'b0);
        send_item(REQ_WRITE, pos_t'(48'h5555_5555_5555), -16'sh5556, 16'sh5555, 1'b1);
    endtask

    initial
    begin
        sb = new();
        rst_n       <= 1'b0;
        start       <= 1'b0;
        req_type    <= REQ_WRITE;
        position    <= '0;
        sample_ch0  <= '0;
        sample_ch1  <= '0;
        last_in_run <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_CHANNELS;
        cfg_data    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // the first accept waits out the clearing sweep on busy
        directed_items();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_reg(CFG_CHANNELS, CFG_DATA_BITS'(chan_plan[ph]));
            write_reg(CFG_LOOKAHEAD, CFG_DATA_BITS'(look_plan[ph]));
            // writes to indexes past the register list must change nothing
            if (ph % 2 == 0)
            begin
                write_reg(CFG_UNUSED_LO, CFG_DATA_BITS'($urandom()));
                write_reg(CFG_UNUSED_HI, CFG_DATA_BITS'($urandom()));
            end
            random_phase(RANDOM_ITEMS / PHASES);
        end
        drain();

        $display("run covered %0d words: %0d writes, %0d snapshots, %0d consumes, %0d seeks",
                 sb.checked, sb.req_count[REQ_WRITE], sb.req_count[REQ_SNAPSHOT],
                 sb.req_count[REQ_CONSUME], sb.req_count[REQ_SEEK]);
        $display("in-window reads %0d (mono %0d), underruns %0d, %0d register settings, %0d errors",
                 sb.hits, sb.mono_hits, sb.underruns, PHASES + 1, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
